FILE: hdl/mcwg_pkg.sv
// ----------------------------------------------------------------------------
// mcwg_pkg: shared types and constants of the multi-channel wave generator
// Channel count, tick width, command and status codes, controller commands.
// ----------------------------------------------------------------------------
package mcwg_pkg;

  // sizes
  localparam int CHANNELS  = 8;
  localparam int TICK_BITS = 24;
  localparam int FIELD_W   = 24;
  localparam int CFG_W     = 4;
  localparam int MASK_W    = 8;
  localparam int CH_W      = 3;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;

  typedef logic [TICK_BITS-1:0] ticks_t;
  typedef logic [FIELD_W-1:0]   field_t;

  // command codes carried by the opcode field
  typedef enum logic [OP_W-1:0] {
    OP_TICK      = 3'd0,
    OP_START     = 3'd1,
    OP_START_LVL = 3'd2,
    OP_DUTY      = 3'd3,
    OP_STOP      = 3'd4,
    OP_QUERY     = 3'd5
  } opcode_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUSY    = 2'd2
  } status_t;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the input word
    logic exec;     // apply it to channel state and load the result
  } ctl_cmd_t;

  // duration field to internal tick width
  function automatic ticks_t to_ticks(field_t f);
    return ticks_t'(f);
  endfunction

  // internal tick width to result field
  function automatic field_t from_ticks(ticks_t t);
    return field_t'(t);
  endfunction

endpackage

FILE: hdl/mcwg_ctrl.sv
// ----------------------------------------------------------------------------
// mcwg_ctrl: sequencing of the wave generator
// Takes one input word at a time, runs it through the datapath and manages
// the output register handshake.
// ----------------------------------------------------------------------------
module mcwg_ctrl import mcwg_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output ctl_cmd_t cmd
);

  ctl_state_t state, state_next;
  logic       out_valid_next;
  logic       can_load;

  // state and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    can_load       = !out_valid || out_ready;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (can_load) begin
          cmd.exec       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hdl/mcwg_datapath.sv
// ----------------------------------------------------------------------------
// mcwg_datapath: channel state, command execution and result register
// All running channels count in parallel on a tick; commands touch one channel.
// ----------------------------------------------------------------------------
module mcwg_datapath import mcwg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  ctl_cmd_t            cmd,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic [OP_W-1:0]     opcode,
  input  logic [CH_W-1:0]     channel,
  input  logic [FIELD_W-1:0]  first_ticks,
  input  logic [FIELD_W-1:0]  second_ticks,
  input  logic                level,
  input  logic                which_phase,
  output logic [STATUS_W-1:0] status,
  output logic [MASK_W-1:0]   levels,
  output logic [MASK_W-1:0]   active_mask,
  output logic [MASK_W-1:0]   toggled_mask,
  output logic [FIELD_W-1:0]  phase_ticks
);

  // configuration
  logic [CFG_W-1:0] channels_in_use;

  // captured input word
  logic [OP_W-1:0]  op;
  logic [CH_W-1:0]  ch;
  ticks_t           first;
  ticks_t           second;
  logic             lvl;
  logic             which;

  // channel state
  logic   out_level     [CHANNELS];
  logic   running       [CHANNELS];
  logic   phase_bit     [CHANNELS];
  ticks_t elapsed_ticks [CHANNELS];
  ticks_t phase0_ticks  [CHANNELS];
  ticks_t phase1_ticks  [CHANNELS];

  logic   out_level_next     [CHANNELS];
  logic   running_next       [CHANNELS];
  logic   phase_bit_next     [CHANNELS];
  ticks_t elapsed_ticks_next [CHANNELS];
  ticks_t phase0_ticks_next  [CHANNELS];
  ticks_t phase1_ticks_next  [CHANNELS];

  // result fields before the output register
  status_t              status_next;
  logic [MASK_W-1:0]    levels_next;
  logic [MASK_W-1:0]    active_next;
  logic [MASK_W-1:0]    toggled_next;
  ticks_t               query_next;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      channels_in_use <= CFG_W'(MASK_W);
    end else if (cfg_wr_en) begin
      channels_in_use <= cfg_wr_data;
    end
  end

  // input word capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op     <= opcode;
      ch     <= channel;
      first  <= to_ticks(first_ticks);
      second <= to_ticks(second_ticks);
      lvl    <= level;
      which  <= which_phase;
    end
  end

  // command and tick evaluation
  always_comb begin
    logic [CHANNELS-1:0] hit;
    logic                valid;
    logic                sel_run;
    logic                sel_lvl;
    logic                sel_phase;
    ticks_t              sel_elapsed;
    ticks_t              sel_p0;
    ticks_t              sel_p1;
    logic                cmd_wr;
    logic [TICK_BITS:0]  period;
    logic [TICK_BITS:0]  rest;
    ticks_t              e1;
    ticks_t              dur;
    ticks_t              dur_new;

    for (int c = 0; c < CHANNELS; c++) begin
      out_level_next[c]     = out_level[c];
      running_next[c]       = running[c];
      phase_bit_next[c]     = phase_bit[c];
      elapsed_ticks_next[c] = elapsed_ticks[c];
      phase0_ticks_next[c]  = phase0_ticks[c];
      phase1_ticks_next[c]  = phase1_ticks[c];
    end

    // selected channel read
    sel_run     = 1'b0;
    sel_lvl     = 1'b0;
    sel_phase   = 1'b0;
    sel_elapsed = '0;
    sel_p0      = '0;
    sel_p1      = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      hit[c] = (int'(ch) == c);
      if (hit[c]) begin
        sel_run     = running[c];
        sel_lvl     = out_level[c];
        sel_phase   = phase_bit[c];
        sel_elapsed = elapsed_ticks[c];
        sel_p0      = phase0_ticks[c];
        sel_p1      = phase1_ticks[c];
      end
    end

    valid        = (int'(ch) < CHANNELS) && ({1'b0, ch} < channels_in_use);
    period       = {1'b0, sel_p0} + {1'b0, sel_p1};
    rest         = period - {1'b0, first};
    cmd_wr       = 1'b0;
    status_next  = ST_OK;
    toggled_next = '0;
    query_next   = '0;
    e1           = '0;
    dur          = '0;
    dur_new      = '0;

    if (opcode_t'(op) == OP_TICK) begin
      // every running channel counts and may toggle
      for (int c = 0; c < CHANNELS; c++) begin
        if (running[c]) begin
          e1  = (elapsed_ticks[c] == '1) ? elapsed_ticks[c] : elapsed_ticks[c] + 1'b1;
          dur = phase_bit[c] ? phase1_ticks[c] : phase0_ticks[c];
          if (e1 >= dur) begin
            out_level_next[c]     = !out_level[c];
            phase_bit_next[c]     = !phase_bit[c];
            elapsed_ticks_next[c] = '0;
            if (c < MASK_W) toggled_next[c] = 1'b1;
            dur_new = phase_bit[c] ? phase0_ticks[c] : phase1_ticks[c];
            if (dur_new == '0) running_next[c] = 1'b0;
          end else begin
            elapsed_ticks_next[c] = e1;
          end
        end
      end
    end else if (!valid) begin
      status_next = ST_INVALID;
    end else begin
      unique case (opcode_t'(op))
        OP_START: begin
          if (first == '0) begin
            status_next = ST_INVALID;
          end else if (sel_run) begin
            status_next = ST_BUSY;
          end else begin
            cmd_wr      = 1'b1;
            sel_p0      = first;
            sel_p1      = second;
            sel_phase   = 1'b0;
            sel_elapsed = '0;
            sel_run     = 1'b1;
          end
        end
        OP_START_LVL: begin
          if (first == '0 || second == '0) begin
            status_next = ST_INVALID;
          end else if (!sel_run) begin
            cmd_wr      = 1'b1;
            sel_lvl     = lvl;
            sel_p0      = first;
            sel_p1      = second;
            sel_phase   = 1'b0;
            sel_elapsed = '0;
            sel_run     = 1'b1;
          end else begin
            // retune: phase, count and level stay
            cmd_wr = 1'b1;
            sel_p0 = first;
            sel_p1 = second;
          end
        end
        OP_DUTY: begin
          if (first == '0) begin
            status_next = ST_INVALID;
          end else if (!sel_run) begin
            cmd_wr      = 1'b1;
            sel_p0      = first;
            sel_p1      = first;
            sel_phase   = 1'b0;
            sel_elapsed = '0;
            sel_run     = 1'b1;
          end else if (period < {1'b0, first} || rest[TICK_BITS]) begin
            status_next = ST_INVALID;
          end else begin
            // keep the period, move the split
            cmd_wr = 1'b1;
            sel_p0 = first;
            sel_p1 = rest[TICK_BITS-1:0];
          end
        end
        OP_STOP: begin
          cmd_wr  = 1'b1;
          sel_run = 1'b0;
          sel_lvl = lvl;
        end
        OP_QUERY: begin
          if (sel_run) query_next = which ? sel_p1 : sel_p0;
        end
        default: status_next = ST_INVALID;
      endcase
    end

    // write back the addressed channel
    for (int c = 0; c < CHANNELS; c++) begin
      if (cmd_wr && hit[c]) begin
        out_level_next[c]     = sel_lvl;
        running_next[c]       = sel_run;
        phase_bit_next[c]     = sel_phase;
        elapsed_ticks_next[c] = sel_elapsed;
        phase0_ticks_next[c]  = sel_p0;
        phase1_ticks_next[c]  = sel_p1;
      end
    end

    // level and activity masks after the step
    levels_next = '0;
    active_next = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      if (c < MASK_W) begin
        levels_next[c] = out_level_next[c];
        active_next[c] = running_next[c];
      end
    end
  end

  // channel state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        out_level[c]     <= 1'b0;
        running[c]       <= 1'b0;
        phase_bit[c]     <= 1'b0;
        elapsed_ticks[c] <= '0;
        phase0_ticks[c]  <= '0;
        phase1_ticks[c]  <= '0;
      end
    end else if (cmd.exec) begin
      for (int c = 0; c < CHANNELS; c++) begin
        out_level[c]     <= out_level_next[c];
        running[c]       <= running_next[c];
        phase_bit[c]     <= phase_bit_next[c];
        elapsed_ticks[c] <= elapsed_ticks_next[c];
        phase0_ticks[c]  <= phase0_ticks_next[c];
        phase1_ticks[c]  <= phase1_ticks_next[c];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status       <= status_next;
      levels       <= levels_next;
      active_mask  <= active_next;
      toggled_mask <= toggled_next;
      phase_ticks  <= from_ticks(query_next);
    end
  end

endmodule

FILE: hdl/multi_channel_wave_generator.sv
// ----------------------------------------------------------------------------
// multi_channel_wave_generator: eight-channel two-phase square wave generator
// Each input word is a tick or a command; each gives one result word.
//
// Input channel (in_valid/in_ready) carries opcode, channel, durations,
// level and phase select. Output channel (out_valid/out_ready) carries
// status, the level and activity masks, the toggle mask and a queried
// duration. The one configuration register, channels_in_use, is written
// through cfg_wr_en/cfg_wr_data; the user must do so only while no word is
// in flight; the block itself does not enforce this. A word is captured,
// then executed once the output register is free; its result loads the
// output register and raises out_valid. No new word is taken before that.
// All running channels count in parallel on a tick.
// The output register stays loaded while the receiver stalls; the next word
// is already taken, and waits in execution until the register frees up.
// Reset stops every channel, clears levels, phases, counts and durations,
// sets channels_in_use to eight and leaves the output channel empty.
// ----------------------------------------------------------------------------
module multi_channel_wave_generator import mcwg_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     opcode,
  input  logic [CH_W-1:0]     channel,
  input  logic [FIELD_W-1:0]  first_ticks,
  input  logic [FIELD_W-1:0]  second_ticks,
  input  logic                level,
  input  logic                which_phase,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [MASK_W-1:0]   levels,
  output logic [MASK_W-1:0]   active_mask,
  output logic [MASK_W-1:0]   toggled_mask,
  output logic [FIELD_W-1:0]  phase_ticks
);

  ctl_cmd_t cmd;

  // sequencing
  mcwg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // channel state and result
  mcwg_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .opcode       (opcode),
    .channel      (channel),
    .first_ticks  (first_ticks),
    .second_ticks (second_ticks),
    .level        (level),
    .which_phase  (which_phase),
    .status       (status),
    .levels       (levels),
    .active_mask  (active_mask),
    .toggled_mask (toggled_mask),
    .phase_ticks  (phase_ticks)
  );

endmodule

FILE: hdl/mcwg_checker.sv
// ----------------------------------------------------------------------------
// mcwg_checker: port-level checks of the wave generator
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module mcwg_checker import mcwg_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [STATUS_W-1:0] status,
  input logic [MASK_W-1:0]   active_mask,
  input logic [MASK_W-1:0]   toggled_mask,
  input logic [FIELD_W-1:0]  phase_ticks
);

  // one word at a time: no word taken right after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted in back-to-back cycles");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(active_mask))
    else $error("stalled result changed");

  // status is one of the three codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_INVALID || status == ST_BUSY))
    else $error("undefined status code");

  // toggles only come from a successful tick
  a_toggle_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && toggled_mask != '0 |-> status == ST_OK && phase_ticks == '0)
    else $error("toggle reported with a command result");

  // a nonzero queried duration needs a running channel
  a_query_active: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase_ticks != '0 |-> status == ST_OK && active_mask != '0)
    else $error("duration returned with no running channel");

endmodule

bind multi_channel_wave_generator mcwg_checker u_mcwg_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .active_mask  (active_mask),
  .toggled_mask (toggled_mask),
  .phase_ticks  (phase_ticks)
);
